FILE: hw/rtl/cbt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbt_pkg: shared types and constants of the cubic Bezier tessellator
// Step count, weight widths, the per-step Bernstein weight table and the
// control bundles passed between the sequencer and the blend pipeline.
// ---------------------------------------------------------------------------
package cbt_pkg;

  localparam int CoordWidthDefault = 20;
  localparam int Steps             = 16;
  localparam int StepW             = $clog2(Steps);
  localparam int StepIdxW          = StepW + 1;   // holds 1..Steps
  localparam int WeightShift       = 12;          // log2(Steps^3)
  localparam int WeightW           = WeightShift + 1;
  localparam int SumGuard          = 14;          // sum width = coord width + guard

  // Integer Bernstein weights for one step, sum is 4096
  typedef struct packed {
    logic [WeightW-1:0] wa;
    logic [WeightW-1:0] wca;
    logic [WeightW-1:0] wcb;
    logic [WeightW-1:0] wb;
  } weight_t;

  // Sequencer status toward the pipeline and the checks
  typedef struct packed {
    logic busy;
    logic last;
  } seq_stat_t;

  // Stage load enables of the blend pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // Weights for step i (1..Steps), u = i/Steps
  function automatic weight_t step_weights(input logic [StepIdxW-1:0] i);
    int unsigned ii;
    int unsigned jj;
    weight_t     w;
    ii    = int'(i);
    jj    = Steps - ii;
    w.wa  = WeightW'(ii * ii * ii);
    w.wca = WeightW'(3 * jj * ii * ii);
    w.wcb = WeightW'(3 * ii * jj * jj);
    w.wb  = WeightW'(jj * jj * jj);
    return w;
  endfunction

endpackage

FILE: hw/rtl/cbt_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbt_if: valid/ready channels of the tessellator
// cbt_in_if carries one curve (four control points), cbt_out_if one point.
// ---------------------------------------------------------------------------
interface cbt_in_if #(
  parameter int COORD_WIDTH = cbt_pkg::CoordWidthDefault
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] end_a_x;
  logic signed [COORD_WIDTH-1:0] end_a_y;
  logic signed [COORD_WIDTH-1:0] end_a_z;
  logic signed [COORD_WIDTH-1:0] ctrl_a_x;
  logic signed [COORD_WIDTH-1:0] ctrl_a_y;
  logic signed [COORD_WIDTH-1:0] ctrl_a_z;
  logic signed [COORD_WIDTH-1:0] ctrl_b_x;
  logic signed [COORD_WIDTH-1:0] ctrl_b_y;
  logic signed [COORD_WIDTH-1:0] ctrl_b_z;
  logic signed [COORD_WIDTH-1:0] end_b_x;
  logic signed [COORD_WIDTH-1:0] end_b_y;
  logic signed [COORD_WIDTH-1:0] end_b_z;

  modport source (
    output valid, end_a_x, end_a_y, end_a_z, ctrl_a_x, ctrl_a_y, ctrl_a_z,
           ctrl_b_x, ctrl_b_y, ctrl_b_z, end_b_x, end_b_y, end_b_z,
    input  ready
  );
  modport sink (
    input  valid, end_a_x, end_a_y, end_a_z, ctrl_a_x, ctrl_a_y, ctrl_a_z,
           ctrl_b_x, ctrl_b_y, ctrl_b_z, end_b_x, end_b_y, end_b_z,
    output ready
  );
endinterface

interface cbt_out_if #(
  parameter int COORD_WIDTH = cbt_pkg::CoordWidthDefault
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic                          last_point;

  modport source (
    output valid, point_x, point_y, point_z, last_point,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, last_point,
    output ready
  );
endinterface

FILE: hw/rtl/cubic_bezier_tessellator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cubic_bezier_tessellator: 16-point cubic Bezier curve tessellator
// Takes one curve (end A, control A, control B, end B) per input beat and
// emits 16 rounded points for u = i/16, i = 1..16, last one equal to end A.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Beat carries                                 Beats per curve
//  in_i     in   end_a, ctrl_a, ctrl_b, end_b (x, y, z each)  1
//  out_o    out  point_x, point_y, point_z, last_point         16
//
//  Throughput: one point per cycle while out_o does not stall; the step
//  counter in cbt_seq issues one step per cycle the pipeline advances.
//  Path to out_o: the curve and step weights are registered in cbt_seq,
//  then pass the multiply, pair add, and final add and round registers.
//  The next curve is taken on the cycle the last step of the current one
//  issues, so back-to-back curves stream without gaps.
//  Reset clears the sequencer busy flag and step counter and the stage valid bits only.
//  A stall on out_o backs up stage by stage; nothing is lost or repeated.
//
// ---------------------------------------------------------------------------
module cubic_bezier_tessellator #(
  parameter int COORD_WIDTH = cbt_pkg::CoordWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbt_in_if.sink    in_i,
  cbt_out_if.source out_o
);

  logic [3:0][2:0][COORD_WIDTH-1:0] coords_in;
  logic [3:0][2:0][COORD_WIDTH-1:0] coords_hold;
  logic [2:0][COORD_WIDTH-1:0]      point;
  cbt_pkg::weight_t                 weights;
  cbt_pkg::seq_stat_t               stat;
  logic                             adv;
  logic                             in_accept;

  // point index: 0 end A, 1 ctrl A, 2 ctrl B, 3 end B; axis 0..2 = x, y, z
  assign coords_in[0][0] = in_i.end_a_x;
  assign coords_in[0][1] = in_i.end_a_y;
  assign coords_in[0][2] = in_i.end_a_z;
  assign coords_in[1][0] = in_i.ctrl_a_x;
  assign coords_in[1][1] = in_i.ctrl_a_y;
  assign coords_in[1][2] = in_i.ctrl_a_z;
  assign coords_in[2][0] = in_i.ctrl_b_x;
  assign coords_in[2][1] = in_i.ctrl_b_y;
  assign coords_in[2][2] = in_i.ctrl_b_z;
  assign coords_in[3][0] = in_i.end_b_x;
  assign coords_in[3][1] = in_i.end_b_y;
  assign coords_in[3][2] = in_i.end_b_z;

  // Step sequencer: holds the curve, walks the 16 steps
  cbt_seq #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .coords_i  (coords_in),
    .adv_i     (adv),
    .coords_o  (coords_hold),
    .weights_o (weights),
    .stat_o    (stat)
  );

  // Blend pipeline: three axes in lockstep, output register at the end
  cbt_pipe #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .coords_i   (coords_hold),
    .weights_i  (weights),
    .adv_o      (adv),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .point_o    (point),
    .last_o     (out_o.last_point)
  );

  assign out_o.point_x = point[0];
  assign out_o.point_y = point[1];
  assign out_o.point_z = point[2];

  assign in_accept = in_i.valid && in_i.ready;

  // A new curve may only overlap the current one on its last step
  a_accept_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && stat.busy |-> stat.last && adv)
    else $error("curve accepted mid-run");

  // Run ends after the last step issues unless a new curve came in
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy && stat.last && adv && !in_accept |=> !stat.busy)
    else $error("sequencer stayed busy after last step");

  // Sequencer only starts a run on an accepted beat
  a_start_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat.busy ##1 stat.busy |-> $past(in_accept))
    else $error("sequencer started without an input beat");

endmodule

FILE: hw/rtl/cbt_seq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbt_seq: curve holding register and step sequencer
// Holds the accepted curve and walks steps 1..16, one per advance, with the
// step weights registered alongside.
// ---------------------------------------------------------------------------
module cbt_seq #(
  parameter int COORD_WIDTH = cbt_pkg::CoordWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [3:0][2:0][COORD_WIDTH-1:0]   coords_i,
  input  logic                               adv_i,
  output logic [3:0][2:0][COORD_WIDTH-1:0]   coords_o,
  output cbt_pkg::weight_t                   weights_o,
  output cbt_pkg::seq_stat_t                 stat_o
);

  logic                                busy_q, busy_d;
  logic [cbt_pkg::StepW-1:0]           step_q, step_d;
  cbt_pkg::weight_t                    w_q, w_d;
  logic [3:0][2:0][COORD_WIDTH-1:0]    hold_q;
  logic                                last_step;
  logic                                advance;
  logic                                accept;

  assign last_step  = (step_q == cbt_pkg::StepW'(cbt_pkg::Steps - 1));
  assign advance    = busy_q && adv_i;
  // next curve may enter on the beat that issues the last step
  assign in_ready_o = !busy_q || (last_step && advance);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (accept) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (advance) begin
      if (last_step) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q + cbt_pkg::StepW'(1);
      end
    end
    w_d = cbt_pkg::step_weights(cbt_pkg::StepIdxW'(step_d) + cbt_pkg::StepIdxW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    if (accept) begin
      hold_q <= coords_i;
    end
  end

  assign coords_o    = hold_q;
  assign weights_o   = w_q;
  assign stat_o.busy = busy_q;
  assign stat_o.last = last_step;

endmodule

FILE: hw/rtl/cbt_blend.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbt_blend: one-axis Bernstein blend datapath
// Multiply, pairwise add, then final add with round-half-up and >>12.
// ---------------------------------------------------------------------------
module cbt_blend #(
  parameter int COORD_WIDTH = cbt_pkg::CoordWidthDefault
) (
  input  logic                          clk_i,
  input  cbt_pkg::stage_en_t            en_i,
  input  logic signed [COORD_WIDTH-1:0] a_i,
  input  logic signed [COORD_WIDTH-1:0] ca_i,
  input  logic signed [COORD_WIDTH-1:0] cb_i,
  input  logic signed [COORD_WIDTH-1:0] b_i,
  input  cbt_pkg::weight_t              w_i,
  output logic signed [COORD_WIDTH-1:0] point_o
);

  localparam int SumW = COORD_WIDTH + cbt_pkg::SumGuard;

  logic signed [SumW-1:0] pa_q, pca_q, pcb_q, pb_q;
  logic signed [SumW-1:0] s01_q, s23_q;
  logic signed [SumW-1:0] total;
  logic signed [COORD_WIDTH-1:0] point_q;

  // weights are unsigned, zero-extend before the signed multiply
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      pa_q  <= SumW'(a_i)  * $signed(SumW'(w_i.wa));
      pca_q <= SumW'(ca_i) * $signed(SumW'(w_i.wca));
      pcb_q <= SumW'(cb_i) * $signed(SumW'(w_i.wcb));
      pb_q  <= SumW'(b_i)  * $signed(SumW'(w_i.wb));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      s01_q <= pa_q + pca_q;
      s23_q <= pcb_q + pb_q;
    end
  end

  assign total = s01_q + s23_q + SumW'(1 << (cbt_pkg::WeightShift - 1));

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      point_q <= total[cbt_pkg::WeightShift +: COORD_WIDTH];
    end
  end

  assign point_o = point_q;

endmodule

FILE: hw/rtl/cbt_pipe.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbt_pipe: three-stage blend pipeline with per-stage valid bits
// Stage 3 is the output register; each stage loads when empty or draining.
// ---------------------------------------------------------------------------
module cbt_pipe #(
  parameter int COORD_WIDTH = cbt_pkg::CoordWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cbt_pkg::seq_stat_t               stat_i,
  input  logic [3:0][2:0][COORD_WIDTH-1:0] coords_i,
  input  cbt_pkg::weight_t                 weights_i,
  output logic                             adv_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0][COORD_WIDTH-1:0]      point_o,
  output logic                             last_o
);

  logic               v1_q, v2_q, v3_q;
  logic               l1_q, l2_q, l3_q;
  cbt_pkg::stage_en_t en;

  assign en.s3 = !v3_q || out_ready_i;
  assign en.s2 = !v2_q || en.s3;
  assign en.s1 = !v1_q || en.s2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= stat_i.busy;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s1) l1_q <= stat_i.last;
    if (en.s2) l2_q <= l1_q;
    if (en.s3) l3_q <= l2_q;
  end

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    cbt_blend #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_blend (
      .clk_i  (clk_i),
      .en_i   (en),
      .a_i    ($signed(coords_i[0][ax])),
      .ca_i   ($signed(coords_i[1][ax])),
      .cb_i   ($signed(coords_i[2][ax])),
      .b_i    ($signed(coords_i[3][ax])),
      .w_i    (weights_i),
      .point_o(point_o[ax])
    );
  end

  assign adv_o       = en.s1;
  assign out_valid_o = v3_q;
  assign last_o      = l3_q;

endmodule
